// ===== rtl/lbbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared types and constants of the LRU block buffer cache.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  localparam int TAG_W      = 31;
  localparam int SLOT_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int SLOT_LSB   = TAG_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_ADD     = 2'd2,
    KIND_DROP    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // One slot of the cache as held in the slot RAM.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               loaded;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // Result transfer, slot_out in the lowest bits.
  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] ref_count_out;
    logic               need_fill;
    logic               hit;
    logic [SLOT_W-1:0]  slot_out;
  } result_t;

endpackage

// ===== rtl/lbbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lru_block_buffer_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// LRU block buffer cache with per-slot reference counts, slot RAM and
// recency-order RAM.
// ----------------------------------------------------------------------------
// Get: walks the recency-order RAM (one position a cycle, two reads deep), then
//   updates the slot it finds and registers the result. Add, drop and release
//   read the slot, write its new count and register the result (a slot out of range
//   goes straight to the result); a release that frees the slot adds a move-to-front pass.
// Throughput: one item at a time, the next taken once the result is registered.
// Reset: synchronous; a clearing pass over every entry fills both RAMs, s_tready low.
module lru_block_buffer_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata: [30:0] block_number, [34:31] slot, [39:35] zero
  input  logic [lbbc_pkg::IN_DATA_W-1:0]   s_tdata,
  // s_tuser: [1:0] kind
  input  logic [lbbc_pkg::KIND_W-1:0]      s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: [3:0] slot_out, [4] hit, [5] need_fill, [13:6] ref_count_out,
  //          [15:14] status
  output logic [lbbc_pkg::OUT_DATA_W-1:0]  m_tdata
);

  import lbbc_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    CLEAR, IDLE, SCAN, GET_FIN, OP_RD, MTF, RESP
  } state_t;

  state_t            state;
  logic [IW-1:0]     clr_cnt;
  // get walk: rp issues order reads, v1/v2 track the two read stages
  logic [IW-1:0]     rp;
  logic              issue_done;
  logic              v1;
  logic              v2;
  logic [IW-1:0]     c2;
  kind_t             kind_r;
  logic [TAG_W-1:0]  tag_r;
  logic [IW-1:0]     slot_r;
  logic              found;
  logic [IW-1:0]     hit_slot;
  entry_t            hit_entry;
  logic              free;
  logic [IW-1:0]     free_slot;
  // move-to-front: write position and the value shifted into it
  logic [IW-1:0]     wp;
  logic [IW-1:0]     carry;
  result_t           res;

  // RAM ports
  logic              slot_we;
  logic [IW-1:0]     slot_waddr;
  entry_t            slot_wdata;
  logic [IW-1:0]     slot_raddr;
  entry_t            slot_rdata;
  logic              ord_we;
  logic [IW-1:0]     ord_waddr;
  logic [IW-1:0]     ord_wdata;
  logic [IW-1:0]     ord_raddr;
  logic [IW-1:0]     ord_rdata;

  logic [SLOT_W-1:0] in_slot;
  logic              in_range;
  logic              accept;

  // computed results of the finishing states
  result_t           get_res;
  result_t           op_res;
  logic [COUNT_W-1:0] op_cnt;

  assign in_slot  = s_tdata[SLOT_LSB +: SLOT_W];
  assign in_range = ({5'd0, in_slot} < 9'(ENTRIES));
  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  lbbc_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  lbbc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  // Result of a get, from the walk's findings.
  always_comb begin
    get_res = '0;
    if (found) begin
      get_res.hit       = 1'b1;
      get_res.need_fill = !hit_entry.loaded;
      get_res.slot_out  = SLOT_W'(hit_slot);
      if (hit_entry.count == COUNT_MAX) begin
        get_res.status        = ST_OVERFLOW;
        get_res.ref_count_out = hit_entry.count;
      end else begin
        get_res.status        = ST_OK;
        get_res.ref_count_out = hit_entry.count + 1'b1;
      end
    end else if (free) begin
      get_res.need_fill     = 1'b1;
      get_res.slot_out      = SLOT_W'(free_slot);
      get_res.ref_count_out = COUNT_W'(1);
      get_res.status        = ST_OK;
    end else begin
      get_res.status = ST_NO_FREE;
    end
  end

  // Count update for release, add and drop on the freshly read slot.
  always_comb begin
    op_cnt = slot_rdata.count;
    op_res = '0;
    op_res.slot_out = SLOT_W'(slot_r);
    op_res.status   = ST_OK;
    if (kind_r == KIND_ADD) begin
      if (slot_rdata.count == COUNT_MAX) begin
        op_res.status = ST_OVERFLOW;
      end else begin
        op_cnt = slot_rdata.count + 1'b1;
      end
    end else begin
      if (slot_rdata.count == '0) begin
        op_res.status = ST_UNDERFLOW;
      end else begin
        op_cnt = slot_rdata.count - 1'b1;
      end
    end
    op_res.ref_count_out = op_cnt;
  end

  // RAM address and write steering.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_r;
    slot_wdata = slot_rdata;
    slot_raddr = IW'(in_slot);
    ord_we     = 1'b0;
    ord_waddr  = wp;
    ord_wdata  = carry;
    ord_raddr  = rp;
    case (state)
      CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt;
        slot_wdata = '0;
        ord_we     = 1'b1;
        ord_waddr  = clr_cnt;
        ord_wdata  = LAST - clr_cnt;
      end
      SCAN: begin
        // order data names the slot whose entry is read next
        slot_raddr = ord_rdata;
      end
      GET_FIN: begin
        if (found) begin
          slot_we           = 1'b1;
          slot_waddr        = hit_slot;
          slot_wdata        = hit_entry;
          slot_wdata.loaded = 1'b1;
          slot_wdata.count  = get_res.ref_count_out;
        end else if (free) begin
          slot_we    = 1'b1;
          slot_waddr = free_slot;
          slot_wdata = '{tag: tag_r, loaded: 1'b1, count: COUNT_W'(1)};
        end
      end
      OP_RD: begin
        slot_we          = 1'b1;
        slot_wdata.count = op_cnt;
        // head of the order, in case the release frees the slot
        ord_raddr        = '0;
      end
      MTF: begin
        ord_we    = 1'b1;
        ord_raddr = wp + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CLEAR;
      clr_cnt    <= '0;
      issue_done <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      found      <= 1'b0;
      free       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      v1 <= (state == SCAN) && !issue_done;
      v2 <= v1;
      c2 <= ord_rdata;
      // RESP reloads the output register itself
      if (m_tvalid && m_tready && state != RESP) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            kind_r     <= kind_t'(s_tuser);
            tag_r      <= s_tdata[TAG_W-1:0];
            slot_r     <= IW'(in_slot);
            rp         <= '0;
            issue_done <= 1'b0;
            found      <= 1'b0;
            free       <= 1'b0;
            if (kind_t'(s_tuser) == KIND_GET) begin
              state <= SCAN;
            end else if (!in_range) begin
              res   <= '{status: ST_NO_FREE, ref_count_out: '0, need_fill: 1'b0,
                         hit: 1'b0, slot_out: in_slot};
              state <= RESP;
            end else begin
              state <= OP_RD;
            end
          end
        end
        SCAN: begin
          if (!issue_done) begin
            if (rp == LAST) begin
              issue_done <= 1'b1;
            end else begin
              rp <= rp + 1'b1;
            end
          end
          if (v2) begin
            // first tag match from the most recent end wins
            if (!found && slot_rdata.tag == tag_r) begin
              found     <= 1'b1;
              hit_slot  <= c2;
              hit_entry <= slot_rdata;
            end
            // last idle slot seen is the least recent one
            if (slot_rdata.count == '0) begin
              free      <= 1'b1;
              free_slot <= c2;
            end
          end
          if (issue_done && !v1 && !v2) begin
            state <= GET_FIN;
          end
        end
        GET_FIN: begin
          res   <= get_res;
          state <= RESP;
        end
        OP_RD: begin
          res <= op_res;
          if (kind_r == KIND_RELEASE && slot_rdata.count == COUNT_W'(1)) begin
            wp    <= '0;
            carry <= slot_r;
            state <= MTF;
          end else begin
            state <= RESP;
          end
        end
        MTF: begin
          // shift each position down by one until the slot's old place
          carry <= ord_rdata;
          if (ord_rdata == slot_r || wp == LAST) begin
            state <= RESP;
          end else begin
            wp <= wp + 1'b1;
          end
        end
        RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lbbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbbc_checker
// Port-level checks on the result stream of the buffer cache.
// ----------------------------------------------------------------------------
module lbbc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [lbbc_pkg::OUT_DATA_W-1:0] m_tdata
);

  import lbbc_pkg::*;

  result_t r;
  assign r = m_tdata;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_no_free: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.status == ST_NO_FREE |->
      !r.hit && !r.need_fill && r.ref_count_out == '0)
    else $error("failed request carries data");

  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.need_fill |-> r.ref_count_out != '0 &&
      (r.status == ST_OK || r.status == ST_OVERFLOW))
    else $error("fill on a slot not held");

  a_under: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.status == ST_UNDERFLOW |->
      r.ref_count_out == '0 && !r.hit && !r.need_fill)
    else $error("underflow with nonzero count");

  a_over: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && r.status == ST_OVERFLOW |-> r.ref_count_out == COUNT_MAX)
    else $error("overflow below saturation");

endmodule

bind lru_block_buffer_cache lbbc_checker u_lbbc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
